// File: rtl/gop_pkg.sv
// ----------------------------------------------------------------------------
// gop_pkg - grid overlay shared definitions
// Sizes, codes and beat/struct types used by the grid overlay modules.
// ----------------------------------------------------------------------------
package gop_pkg;

  localparam int MAX_LINES   = 15;
  localparam int DIM_BITS    = 12;
  localparam int FRAC_BITS   = 16;
  localparam int TABLE_DEPTH = MAX_LINES + 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SIZE_W      = DIM_BITS + 1;
  localparam int LCNT_W      = 4;
  localparam int NUM_W       = SIZE_W + FRAC_BITS;
  localparam int IDX_W       = NUM_W + 1;
  localparam int DIVR_W      = LCNT_W + 1;
  localparam int STEP_W      = $clog2(NUM_W);
  localparam int LEFT_W      = LCNT_W - 1;
  localparam int CH_W        = 8;
  localparam int SUM_W       = CH_W + 2;
  localparam int CFG_W       = SIZE_W;
  localparam int CFG_ADDR_W  = 2;

  localparam logic [SIZE_W-1:0] SIZE_MAX     = SIZE_W'(1 << DIM_BITS);
  localparam logic [SIZE_W-1:0] WIDTH_RST    = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RST   = SIZE_W'(480);
  localparam logic [LCNT_W-1:0] LINES_MAX    = LCNT_W'(MAX_LINES);
  localparam logic [SUM_W-1:0]  BRIGHT_LIMIT = SUM_W'(3 * 127);
  localparam logic [CH_W-1:0]   CH_WHITE     = CH_W'(255);
  localparam logic [CH_W-1:0]   CH_BLACK     = '0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_LINE_COUNT   = 2'd2
  } cfg_addr_t;

  // table entry shifting along the cell row
  typedef struct packed {
    logic                shift;
    logic [DIM_BITS-1:0] pos;
  } load_t;

  // per-cell entry enables
  typedef struct packed {
    logic col;
    logic row;
  } act_t;

  // pixel travelling through the cell row
  typedef struct packed {
    logic                valid;
    logic [CH_W-1:0]     red;
    logic [CH_W-1:0]     green;
    logic [CH_W-1:0]     blue;
    logic [DIM_BITS-1:0] col;
    logic [DIM_BITS-1:0] row;
    logic                last;
    logic                hit;
    logic                par;
  } pix_t;

endpackage

// File: rtl/gop_cell.sv
// ----------------------------------------------------------------------------
// gop_cell - one cell of the grid line compare row
// Holds one column and one row line position and checks a passing pixel.
// ----------------------------------------------------------------------------
module gop_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  gop_pkg::load_t ld_c_i,
  input  gop_pkg::load_t ld_r_i,
  input  gop_pkg::act_t  act,
  input  gop_pkg::pix_t  pix_i,
  output gop_pkg::load_t ld_c_o,
  output gop_pkg::load_t ld_r_o,
  output gop_pkg::pix_t  pix_o
);

  logic [gop_pkg::DIM_BITS-1:0] col_pos_r;
  logic [gop_pkg::DIM_BITS-1:0] row_pos_r;
  gop_pkg::pix_t                pix_r;
  gop_pkg::pix_t                pix_nxt;
  logic                         mc;
  logic                         mr;

  always_comb begin
    mc            = act.col && (pix_i.col == col_pos_r);
    mr            = act.row && (pix_i.row == row_pos_r);
    pix_nxt       = pix_i;
    pix_nxt.hit   = pix_i.hit | mc | mr;
    pix_nxt.par   = pix_i.par ^ mc ^ mr;
  end

  always_ff @(posedge clk) begin
    if (ld_c_i.shift) begin
      col_pos_r <= ld_c_i.pos;
    end
    if (ld_r_i.shift) begin
      row_pos_r <= ld_r_i.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r.valid <= 1'b0;
    end else if (adv) begin
      pix_r <= pix_nxt;
    end
  end

  assign ld_c_o = '{shift: ld_c_i.shift, pos: col_pos_r};
  assign ld_r_o = '{shift: ld_r_i.shift, pos: row_pos_r};
  assign pix_o  = pix_r;

endmodule

// File: rtl/gop_tbuild.sv
// ----------------------------------------------------------------------------
// gop_tbuild - grid line position builder for one dimension
// Bit-serial divide for the spacing, then emits the positions in turn.
// ----------------------------------------------------------------------------
module gop_tbuild (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gop_pkg::SIZE_W-1:0] size,
  input  logic [gop_pkg::LCNT_W-1:0] lines,
  output logic                       busy,
  output gop_pkg::load_t             ld,
  output logic [gop_pkg::CNT_W-1:0]  count
);

  typedef enum logic [2:0] {
    B_IDLE, B_DIV, B_SEED, B_CTR_A, B_CTR_B, B_PAIR_A, B_PAIR_B, B_STEP
  } state_t;

  localparam int PROD_W = gop_pkg::NUM_W + gop_pkg::LEFT_W;

  state_t                              state_r, state_nxt;
  logic [gop_pkg::SIZE_W-1:0]          size_r, size_nxt;
  logic [gop_pkg::LCNT_W-1:0]          n_r, n_nxt;
  logic [gop_pkg::DIVR_W-1:0]          rem_r, rem_nxt;
  logic [gop_pkg::NUM_W-1:0]           num_r, num_nxt;
  logic [gop_pkg::STEP_W-1:0]          step_r, step_nxt;
  logic signed [gop_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [gop_pkg::LEFT_W-1:0]          left_r, left_nxt;
  logic [gop_pkg::DIM_BITS-1:0]        p_r, p_nxt;
  logic [gop_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;

  logic [gop_pkg::DIVR_W-1:0]          dvs;
  logic [gop_pkg::DIVR_W:0]            rem_sh;
  logic                                q_bit;
  logic [PROD_W-1:0]                   prod;
  logic signed [gop_pkg::IDX_W-1:0]    rnd;
  logic [gop_pkg::DIM_BITS-1:0]        p_now;
  logic [gop_pkg::SIZE_W-1:0]          mirror;
  logic [gop_pkg::DIM_BITS-1:0]        center;
  logic [gop_pkg::SIZE_W-1:0]          size_m1;

  always_comb begin
    dvs     = {1'b0, n_r} + gop_pkg::DIVR_W'(1);
    rem_sh  = {rem_r, num_r[gop_pkg::NUM_W-1]};
    q_bit   = (rem_sh >= {1'b0, dvs});
    prod    = num_r * n_r[gop_pkg::LCNT_W-1:1];
    rnd     = idx_r + gop_pkg::IDX_W'(1 << (gop_pkg::FRAC_BITS - 1));
    p_now   = rnd[gop_pkg::FRAC_BITS +: gop_pkg::DIM_BITS];
    mirror  = size_r - gop_pkg::SIZE_W'(1) - {1'b0, p_r};
    center  = size_r[gop_pkg::SIZE_W-1:1];
    size_m1 = size_r - gop_pkg::SIZE_W'(1);

    state_nxt = state_r;
    size_nxt  = size_r;
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    p_nxt     = p_r;
    cnt_nxt   = cnt_r;
    ld        = '{shift: 1'b0, pos: p_now};

    unique case (state_r)
      B_IDLE: begin
        if (start) begin
          size_nxt  = size;
          n_nxt     = lines;
          cnt_nxt   = '0;
          rem_nxt   = '0;
          num_nxt   = {size, {gop_pkg::FRAC_BITS{1'b0}}};
          step_nxt  = '0;
          state_nxt = (lines == '0) ? B_IDLE : B_DIV;
        end
      end
      B_DIV: begin
        rem_nxt  = q_bit ? gop_pkg::DIVR_W'(rem_sh - {1'b0, dvs})
                         : rem_sh[gop_pkg::DIVR_W-1:0];
        num_nxt  = {num_r[gop_pkg::NUM_W-2:0], q_bit};
        step_nxt = step_r + gop_pkg::STEP_W'(1);
        if (step_r == gop_pkg::STEP_W'(gop_pkg::NUM_W - 1)) begin
          state_nxt = B_SEED;
        end
      end
      B_SEED: begin
        left_nxt = gop_pkg::LEFT_W'((n_r - gop_pkg::LCNT_W'(1)) >> 1);
        if (n_r[0]) begin
          idx_nxt   = gop_pkg::IDX_W'({size_m1, {(gop_pkg::FRAC_BITS - 1){1'b0}}});
          state_nxt = B_CTR_A;
        end else begin
          idx_nxt   = prod[gop_pkg::IDX_W-1:0];
          state_nxt = B_PAIR_A;
        end
      end
      B_CTR_A: begin
        ld        = '{shift: 1'b1, pos: center};
        cnt_nxt   = cnt_r + gop_pkg::CNT_W'(1);
        state_nxt = size_r[0] ? B_STEP : B_CTR_B;
      end
      B_CTR_B: begin
        ld        = '{shift: 1'b1, pos: center - gop_pkg::DIM_BITS'(1)};
        cnt_nxt   = cnt_r + gop_pkg::CNT_W'(1);
        state_nxt = B_STEP;
      end
      B_PAIR_A: begin
        ld        = '{shift: 1'b1, pos: p_now};
        p_nxt     = p_now;
        cnt_nxt   = cnt_r + gop_pkg::CNT_W'(1);
        state_nxt = B_PAIR_B;
      end
      B_PAIR_B: begin
        ld        = '{shift: 1'b1, pos: mirror[gop_pkg::DIM_BITS-1:0]};
        cnt_nxt   = cnt_r + gop_pkg::CNT_W'(1);
        state_nxt = B_STEP;
      end
      B_STEP: begin
        if (left_r == '0) begin
          state_nxt = B_IDLE;
        end else begin
          idx_nxt   = idx_r - gop_pkg::IDX_W'(num_r);
          left_nxt  = left_r - gop_pkg::LEFT_W'(1);
          state_nxt = B_PAIR_A;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      size_r  <= size_nxt;
      n_r     <= n_nxt;
      rem_r   <= rem_nxt;
      num_r   <= num_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
      left_r  <= left_nxt;
      p_r     <= p_nxt;
    end
  end

  assign busy  = (state_r != B_IDLE);
  assign count = cnt_r;

endmodule

// File: rtl/grid_overlay_pixel_stream.sv
// ----------------------------------------------------------------------------
// grid_overlay_pixel_stream - grid line overlay on a raster RGB stream
// Marks evenly spaced column and row lines by mapping hit pixels to
// black or white.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel per beat, tdata = red, green, blue (low bits first),
//           tuser = frame start. out_* : overlaid pixel, tlast = last pixel
//           of the frame. cfg_* : width, height and line count, applied at
//           the next frame start.
//   Path: an input beat passes the 16 compare cells and then the output
//   register before it shows on out_tvalid.
//   Throughput: one pixel per cycle inside a frame unless the output stalls.
//   A frame-start beat is held until the cell row drains, then both
//   position tables are rebuilt: 29 divide steps, then the positions
//   load one by one by shifting into the cells.
//   Reset: 640x480, no lines, pixels pass unchanged until a frame start.
//   Stall: the cell row and output register advance only while the output
//   register is free or being taken; otherwise the input is held off.
// ----------------------------------------------------------------------------
module grid_overlay_pixel_stream (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // in_red, in_green, in_blue
  input  logic                           in_tuser,   // frame_start
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // out_red, out_green, out_blue
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [gop_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gop_pkg::CFG_W-1:0]      cfg_wdata
);

  typedef enum logic [2:0] {T_RUN, T_DRAIN, T_KICK, T_BUILD, T_FS} state_t;

  localparam int DEPTH = gop_pkg::TABLE_DEPTH;
  localparam int DB    = gop_pkg::DIM_BITS;
  localparam int SW    = gop_pkg::SIZE_W;
  localparam int CW    = gop_pkg::CH_W;

  state_t                     state_r, state_nxt;
  logic [SW-1:0]              fw_r, fw_nxt;
  logic [SW-1:0]              fh_r, fh_nxt;
  logic [gop_pkg::LCNT_W-1:0] lc_r, lc_nxt;
  logic [SW-1:0]              wl_r, wl_nxt;
  logic [SW-1:0]              hl_r, hl_nxt;
  logic [DB-1:0]              col_r, col_nxt;
  logic [DB-1:0]              row_r, row_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [3*CW-1:0]            out_data_r, out_data_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       adv;
  logic                       in_accept;
  logic                       chain_busy;
  logic                       kick;
  logic                       busy_c;
  logic                       busy_r;
  logic [gop_pkg::CNT_W-1:0]  cnt_c;
  logic [gop_pkg::CNT_W-1:0]  cnt_r;
  logic [SW-1:0]              w_clamp;
  logic [SW-1:0]              h_clamp;
  logic [gop_pkg::LCNT_W-1:0] n_sat;
  logic [DB-1:0]              col_inc;
  logic [DB-1:0]              row_inc;
  logic                       last_px;
  logic [gop_pkg::SUM_W-1:0]  luma_sum;
  logic                       black;
  logic [CW-1:0]              fill;
  logic [DEPTH-1:0]           busy_v;

  gop_pkg::pix_t              pix_in;
  gop_pkg::pix_t              pix_w [0:DEPTH];
  gop_pkg::load_t             ldc_w [0:DEPTH];
  gop_pkg::load_t             ldr_w [0:DEPTH];

  // ---- table builders ----
  gop_tbuild u_build_col (
    .clk   (clk),
    .rst_n (rst_n),
    .start (kick),
    .size  (w_clamp),
    .lines (n_sat),
    .busy  (busy_c),
    .ld    (ldc_w[0]),
    .count (cnt_c)
  );

  gop_tbuild u_build_row (
    .clk   (clk),
    .rst_n (rst_n),
    .start (kick),
    .size  (h_clamp),
    .lines (n_sat),
    .busy  (busy_r),
    .ld    (ldr_w[0]),
    .count (cnt_r)
  );

  // ---- compare cell row ----
  assign pix_w[0] = pix_in;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [gop_pkg::CNT_W-1:0] CELL_IDX = gop_pkg::CNT_W'(i);
    gop_pkg::act_t act;

    assign act       = '{col: (CELL_IDX < cnt_c), row: (CELL_IDX < cnt_r)};
    assign busy_v[i] = pix_w[i+1].valid;

    gop_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ld_c_i (ldc_w[i]),
      .ld_r_i (ldr_w[i]),
      .act    (act),
      .pix_i  (pix_w[i]),
      .ld_c_o (ldc_w[i+1]),
      .ld_r_o (ldr_w[i+1]),
      .pix_o  (pix_w[i+1])
    );
  end

  // ---- control ----
  always_comb begin
    adv        = !out_valid_r || out_tready;
    in_tready  = adv && (((state_r == T_RUN) && !in_tuser) || (state_r == T_FS));
    in_accept  = in_tvalid && in_tready;
    chain_busy = |busy_v;
    kick       = (state_r == T_KICK);

    if (fw_r == '0) begin
      w_clamp = SW'(1);
    end else if (fw_r > gop_pkg::SIZE_MAX) begin
      w_clamp = gop_pkg::SIZE_MAX;
    end else begin
      w_clamp = fw_r;
    end
    if (fh_r == '0) begin
      h_clamp = SW'(1);
    end else if (fh_r > gop_pkg::SIZE_MAX) begin
      h_clamp = gop_pkg::SIZE_MAX;
    end else begin
      h_clamp = fh_r;
    end
    n_sat = (lc_r > gop_pkg::LINES_MAX) ? gop_pkg::LINES_MAX : lc_r;

    last_px = ({1'b0, col_r} == wl_r - SW'(1)) && ({1'b0, row_r} == hl_r - SW'(1));
    col_inc = col_r + DB'(1);
    row_inc = row_r + DB'(1);

    pix_in.valid = in_accept;
    pix_in.red   = in_tdata[CW-1:0];
    pix_in.green = in_tdata[2*CW-1:CW];
    pix_in.blue  = in_tdata[3*CW-1:2*CW];
    pix_in.col   = col_r;
    pix_in.row   = row_r;
    pix_in.last  = last_px;
    pix_in.hit   = 1'b0;
    pix_in.par   = 1'b0;

    state_nxt = state_r;
    fw_nxt    = fw_r;
    fh_nxt    = fh_r;
    lc_nxt    = lc_r;
    wl_nxt    = wl_r;
    hl_nxt    = hl_r;
    col_nxt   = col_r;
    row_nxt   = row_r;

    if (cfg_we) begin
      unique case (gop_pkg::cfg_addr_t'(cfg_addr))
        gop_pkg::CFG_FRAME_WIDTH:  fw_nxt = cfg_wdata[SW-1:0];
        gop_pkg::CFG_FRAME_HEIGHT: fh_nxt = cfg_wdata[SW-1:0];
        gop_pkg::CFG_LINE_COUNT:   lc_nxt = cfg_wdata[gop_pkg::LCNT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      T_RUN: begin
        if (in_tvalid && in_tuser) begin
          state_nxt = T_DRAIN;
        end
      end
      T_DRAIN: begin
        if (!chain_busy) begin
          state_nxt = T_KICK;
        end
      end
      T_KICK: begin
        wl_nxt    = w_clamp;
        hl_nxt    = h_clamp;
        col_nxt   = '0;
        row_nxt   = '0;
        state_nxt = T_BUILD;
      end
      T_BUILD: begin
        if (!busy_c && !busy_r) begin
          state_nxt = T_FS;
        end
      end
      T_FS: begin
        if (in_accept) begin
          state_nxt = T_RUN;
        end
      end
      default: state_nxt = T_RUN;
    endcase

    if (in_accept) begin
      if (({1'b0, col_inc} >= wl_r) || (col_inc == '0)) begin
        col_nxt = '0;
        row_nxt = ({1'b0, row_inc} >= hl_r) ? '0 : row_inc;
      end else begin
        col_nxt = col_inc;
      end
    end

    // ---- output mapping ----
    luma_sum = gop_pkg::SUM_W'(pix_w[DEPTH].red) + gop_pkg::SUM_W'(pix_w[DEPTH].green)
             + gop_pkg::SUM_W'(pix_w[DEPTH].blue);
    black    = (luma_sum > gop_pkg::BRIGHT_LIMIT) ~^ pix_w[DEPTH].par;
    fill     = black ? gop_pkg::CH_BLACK : gop_pkg::CH_WHITE;

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = pix_w[DEPTH].valid;
      out_last_nxt  = pix_w[DEPTH].last;
      out_data_nxt  = pix_w[DEPTH].hit ? {fill, fill, fill}
                    : {pix_w[DEPTH].blue, pix_w[DEPTH].green, pix_w[DEPTH].red};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_RUN;
      fw_r        <= gop_pkg::WIDTH_RST;
      fh_r        <= gop_pkg::HEIGHT_RST;
      lc_r        <= '0;
      wl_r        <= gop_pkg::WIDTH_RST;
      hl_r        <= gop_pkg::HEIGHT_RST;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fw_r        <= fw_nxt;
      fh_r        <= fh_nxt;
      lc_r        <= lc_nxt;
      wl_r        <= wl_nxt;
      hl_r        <= hl_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // a frame-start beat only enters once the tables are rebuilt
  a_fs_after_build: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |-> (state_r == T_FS))
    else $error("frame start accepted before table rebuild");

  // tables must never change under pixels in flight
  a_empty_at_fs: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == T_BUILD) || (state_r == T_FS)) |-> !chain_busy)
    else $error("cell row not empty during table load");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_c <= gop_pkg::CNT_W'(DEPTH)) && (cnt_r <= gop_pkg::CNT_W'(DEPTH)))
    else $error("position entry count beyond table depth");

  // the shift stream must end where the last cell takes it
  a_load_tail: assert property (@(posedge clk) disable iff (!rst_n)
    ldc_w[DEPTH].shift |-> busy_c)
    else $error("column table shift outside of build");
`endif

endmodule
